>>> hw/rtl/fpsqrt_pkg.sv
// Package for the Q16.16 fixed-point square root core.
// Holds controller states, command and status structs, and algorithm constants.
// No dependencies.
package fpsqrt_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned RootW  = 25;

  // Operand bits that select the high starting probe
  localparam logic [ValueW-1:0] HighMask   = 32'hFFF0_0000;
  localparam logic [ValueW-1:0] ProbeHigh  = 32'h4000_0000;
  localparam logic [ValueW-1:0] ProbeLow   = 32'h0004_0000;
  localparam logic [ValueW-1:0] ProbePass2 = 32'h0000_4000;
  localparam logic [ValueW-1:0] RemLimit   = 32'h0000_FFFF;
  localparam logic [ValueW-1:0] HalfStep   = 32'h0000_8000;

  typedef enum logic [2:0] {
    StIdle,
    StAlign,
    StPass1,
    StRescale,
    StPass2,
    StRound,
    StDone
  } fpsqrt_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic align;
    logic step;
    logic rescale;
    logic finish;
  } fpsqrt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic probe_gt_rem;
    logic probe_zero;
  } fpsqrt_status_t;

endpackage

>>> hw/rtl/fpsqrt_datapath.sv
// Datapath of the square root core: remainder, root accumulator and probe registers.
// Depends on fpsqrt_pkg; driven by fpsqrt_ctrl through command and status structs.
module fpsqrt_datapath (
  input  logic                                clk_i,
  input  logic signed [fpsqrt_pkg::ValueW-1:0] value_i,
  input  fpsqrt_pkg::fpsqrt_cmd_t             cmd_i,
  output fpsqrt_pkg::fpsqrt_status_t          status_o,
  output logic signed [fpsqrt_pkg::RootW-1:0]  root_o
);
  import fpsqrt_pkg::*;

  logic [ValueW-1:0] rem_q, rem_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [ValueW-1:0] probe_q, probe_d;
  logic              neg_q, neg_d;
  logic [RootW-1:0]  root_q, root_d;

  logic [ValueW-1:0] mag;
  logic [ValueW-1:0] trial;
  logic [ValueW-1:0] rem_adj;
  logic [ValueW-1:0] acc_rnd;

  // Magnitude of the operand, wrapping for the most negative value
  assign mag     = value_i[ValueW-1] ? (~value_i + 1'b1) : value_i;
  assign trial   = acc_q + probe_q;
  assign rem_adj = rem_q - acc_q;
  assign acc_rnd = (rem_q > acc_q) ? (acc_q + 1'b1) : acc_q;

  // Next values of the working registers
  always_comb begin
    rem_d   = rem_q;
    acc_d   = acc_q;
    probe_d = probe_q;
    neg_d   = neg_q;
    root_d  = root_q;
    priority if (cmd_i.load) begin
      rem_d   = mag;
      acc_d   = '0;
      neg_d   = value_i[ValueW-1];
      probe_d = ((mag & HighMask) != '0) ? ProbeHigh : ProbeLow;
    end else if (cmd_i.align) begin
      probe_d = probe_q >> 2;
    end else if (cmd_i.step) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        acc_d = (acc_q >> 1) + probe_q;
      end else begin
        acc_d = acc_q >> 1;
      end
      probe_d = probe_q >> 2;
    end else if (cmd_i.rescale) begin
      // Commit a half step when the remainder is too large to shift
      if (rem_q > RemLimit) begin
        rem_d = (rem_adj << 16) - HalfStep;
        acc_d = (acc_q << 16) + HalfStep;
      end else begin
        rem_d = rem_q << 16;
        acc_d = acc_q << 16;
      end
      probe_d = ProbePass2;
    end else if (cmd_i.finish) begin
      root_d = neg_q ? RootW'(~acc_rnd + 1'b1) : acc_rnd[RootW-1:0];
    end
  end

  // Hold the payload registers; no reset needed
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    acc_q   <= acc_d;
    probe_q <= probe_d;
    neg_q   <= neg_d;
    root_q  <= root_d;
  end

  assign status_o.probe_gt_rem = probe_q > rem_q;
  assign status_o.probe_zero   = (probe_q == '0);
  assign root_o                = root_q;

endmodule

>>> hw/rtl/fpsqrt_ctrl.sv
// Controller state machine of the square root core.
// Depends on fpsqrt_pkg; sequences fpsqrt_datapath through the command struct.
module fpsqrt_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  output logic                        done_o,
  input  fpsqrt_pkg::fpsqrt_status_t  status_i,
  output fpsqrt_pkg::fpsqrt_cmd_t     cmd_o
);
  import fpsqrt_pkg::*;

  fpsqrt_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (start) state_d = StAlign;
      StAlign:   if (!status_i.probe_gt_rem) state_d = StPass1;
      StPass1:   if (status_i.probe_zero) state_d = StRescale;
      StRescale: state_d = StPass2;
      StPass2:   if (status_i.probe_zero) state_d = StRound;
      StRound:   state_d = StDone;
      StDone:    state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      StAlign:   cmd_o.align   = status_i.probe_gt_rem;
      StPass1:   cmd_o.step    = !status_i.probe_zero;
      StRescale: cmd_o.rescale = 1'b1;
      StPass2:   cmd_o.step    = !status_i.probe_zero;
      StRound:   cmd_o.finish  = 1'b1;
      StDone:    done_o        = 1'b1;
      default:   busy          = 1'b1;
    endcase
  end

  // Advance the state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Accepted operand makes the core busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("operand transfer did not start work");

  // Result strobe lasts one cycle and frees the core
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy)) else $error("result strobe not followed by idle");

  // Result strobe only follows the rounding step
  a_done_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(cmd_o.finish)) else $error("result strobe without rounding");

  // Only one command at a time reaches the datapath
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("conflicting datapath commands");

endmodule

>>> hw/rtl/fixed_point_square_root_core.sv
// Q16.16 square root core: rounded root of the operand magnitude, sign copied.
// Sequence: after the start transfer the probe is aligned, then the restoring root loop
// runs (one probe position per cycle, plus 8 low bits), then the root is rounded and strobed.
// Throughput: one operand at a time; a new start is taken the cycle after the strobe.
// Reset: asynchronous active-low rst_ni returns the controller to idle.
// Results are strobed for one cycle; the receiver cannot stall.
module fixed_point_square_root_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [fpsqrt_pkg::ValueW-1:0] value_i,
  output logic                                done_o,
  output logic signed [fpsqrt_pkg::RootW-1:0]  root_o
);
  import fpsqrt_pkg::*;

  fpsqrt_cmd_t    cmd;
  fpsqrt_status_t status;

  fpsqrt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  fpsqrt_datapath u_datapath (
    .clk_i    (clk_i),
    .value_i  (value_i),
    .cmd_i    (cmd),
    .status_o (status),
    .root_o   (root_o)
  );

endmodule

>>> tb/fpsqrt_checker.sv
// Result checker for the Q16.16 square root core: predicts each root and compares.
// Watches the start/busy transfer and the done strobe; uses fpsqrt_pkg constants.
`timescale 1ns / 1ps

module fpsqrt_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic signed [fpsqrt_pkg::ValueW-1:0] value_i,
  input  logic                                done_i,
  input  logic signed [fpsqrt_pkg::RootW-1:0]  root_i,
  output int unsigned                         mismatch_count_o,
  output int unsigned                         pending_roots_o
);

  import fpsqrt_pkg::*;

  logic [RootW-1:0] expected_roots [$];
  int unsigned      mismatch_count = 0;
  int unsigned      pending_count  = 0;

  // Restoring root of the magnitude in two passes, rounded, sign copied
  function automatic logic [RootW-1:0] predict_root(input logic [ValueW-1:0] operand);
    logic [ValueW-1:0] mag;
    logic [ValueW-1:0] rem;
    logic [ValueW-1:0] acc;
    logic [ValueW-1:0] probe;
    logic [ValueW-1:0] trial;
    logic              neg;
    neg = operand[ValueW-1];
    mag = neg ? (32'd0 - operand) : operand;
    rem = mag;
    acc = '0;
    probe = ((rem & HighMask) != '0) ? ProbeHigh : ProbeLow;
    while (probe > rem) probe = probe >> 2;
    for (int pass = 0; pass < 2; pass++) begin
      while (probe != '0) begin
        trial = acc + probe;
        if (rem >= trial) begin
          rem = rem - trial;
          acc = (acc >> 1) + probe;
        end else begin
          acc = acc >> 1;
        end
        probe = probe >> 2;
      end
      // Rescale by 2^16; commit a half step first when the remainder is too wide
      if (pass == 0) begin
        if (rem > RemLimit) begin
          rem = rem - acc;
          rem = (rem << 16) - HalfStep;
          acc = (acc << 16) + HalfStep;
        end else begin
          rem = rem << 16;
          acc = acc << 16;
        end
        probe = ProbePass2;
      end
    end
    if (rem > acc) acc = acc + 1;
    if (neg) acc = 32'd0 - acc;
    return acc[RootW-1:0];
  endfunction

  // Queue the prediction on each start transfer, then match the strobed root
  always @(posedge clk_i) begin
    logic [RootW-1:0] want;
    if (rst_ni) begin
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        expected_roots.push_back(predict_root(value_i));
      end
      if (done_i === 1'b1) begin
        if (expected_roots.size() == 0) begin
          $error("root: unexpected result, expected none, actual %0d", root_i);
          mismatch_count++;
        end else begin
          want = expected_roots.pop_front();
          if (root_i !== want) begin
            $error("root: expected %0d, actual %0d", $signed(want), root_i);
            mismatch_count++;
          end
        end
      end else if (done_i !== 1'b0) begin
        $error("done_o: expected 0 or 1, actual %b", done_i);
        mismatch_count++;
      end
      pending_count = expected_roots.size();
    end
  end

  assign mismatch_count_o = mismatch_count;
  assign pending_roots_o  = pending_count;

endmodule

>>> tb/testbench.sv
// Top of the Q16.16 square root testbench: clock, reset, operand stimulus, verdict.
// Depends on fixed_point_square_root_core, fpsqrt_pkg and fpsqrt_checker.
`timescale 1ns / 1ps

module testbench;

  import fpsqrt_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned TailCycles  = 40;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic signed [ValueW-1:0] value_i;
  logic                     done_o;
  logic signed [RootW-1:0]  root_o;

  int unsigned mismatch_count;
  int unsigned pending_roots;
  int unsigned cycle_count = 0;

  logic [ValueW-1:0] directed_ops [0:23];

  fixed_point_square_root_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .value_i(value_i),
    .done_o (done_o),
    .root_o (root_o)
  );

  fpsqrt_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .value_i         (value_i),
    .done_i          (done_o),
    .root_i          (root_o),
    .mismatch_count_o(mismatch_count),
    .pending_roots_o (pending_roots)
  );

  always #4 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Pick an operand: full range, small, just above a square, or large
  function automatic logic [ValueW-1:0] random_operand();
    logic [ValueW-1:0] mag;
    int unsigned       n;
    case ($urandom_range(3))
      0: return $urandom;
      1: mag = $urandom_range(32'h000F_FFFF, 0);
      2: begin
        n   = $urandom_range(46340, 0);
        mag = n * n + $urandom_range(2 * n, 0);
      end
      default: mag = $urandom_range(32'h7FFF_FFFF, 32'h3FFF_0000);
    endcase
    return $urandom_range(1) ? (32'd0 - mag) : mag;
  endfunction

  // Idle the sender cycle by cycle at random, then keep start high until the transfer
  task automatic send_operand(input logic [ValueW-1:0] operand, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start   <= 1'b0;
      value_i <= $urandom;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= operand;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    value_i     = '0;
    directed_ops = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h000F_FFFF,
      32'h0010_0000, 32'hFFF0_0000, 32'h0004_0000, 32'h0003_FFFF,
      32'h0000_0002, 32'h0000_0003, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h7FFF_0000, 32'h0009_0000, 32'h4000_0000, 32'h4000_FFFF,
      32'h4001_0000, 32'hBFFF_0000, 32'h7FFE_A810, 32'h8000_0001
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners, no hold-off
    foreach (directed_ops[i]) send_operand(directed_ops[i], 0);

    // Random operands: sender idles 31%, then 55%, then never
    for (int i = 0; i < RandomItems; i++) begin
      if (i < RandomItems / 3)          send_operand(random_operand(), 31);
      else if (i < 2 * RandomItems / 3) send_operand(random_operand(), 55);
      else                              send_operand(random_operand(), 0);
    end
    start <= 1'b0;

    // Drain outstanding roots, then let the core settle
    do @(posedge clk_i); while (pending_roots != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
